[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the rtl core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, muted while reset is high
`define ASSERT_CLK_RST(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("%m: assertion failed");

// checked on every rising edge, reset included
`define ASSERT_CLK(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("%m: assertion failed");

`endif

[design/uer_pkg.sv]
// ----------------------------------------------------------------------------
// uer_pkg
// action codes, phase codes and fixed constants of the echo ranger
// ----------------------------------------------------------------------------
package uer_pkg;

  // event kinds carried in tuser
  localparam logic [2:0] ACT_TRIGGER = 3'd0;
  localparam logic [2:0] ACT_RISE    = 3'd1;
  localparam logic [2:0] ACT_FALL    = 3'd2;
  localparam logic [2:0] ACT_TIMEOUT = 3'd3;
  localparam logic [2:0] ACT_READ    = 3'd4;

  // measurement phase
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RISE = 2'd1;
  localparam logic [1:0] PH_FALL = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_TIMEOUT_MS = 2'd0;
  localparam logic [1:0] REG_CM_PER_US  = 2'd1;
  localparam logic [1:0] REG_NO_ECHO    = 2'd2;

  // register reset values
  localparam logic [15:0] TIMEOUT_MS_RST = 16'd60;
  localparam logic [15:0] CM_PER_US_RST  = 16'd1124;
  localparam logic [15:0] NO_ECHO_RST    = 16'hFFF0;

  // largest reported distance, q11.4 cm
  localparam logic [15:0] DIST_MAX   = 16'd32767;
  // half of one q4 step in the q.16 product
  localparam logic [15:0] ROUND_HALF = 16'd2048;

  // width of m_tdata
  localparam int OUT_W = 24;

endpackage

[design/ultrasonic_echo_ranger_core.sv]
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Echo ranging controller for a trigger/echo ultrasonic sensor. Each input
// transaction is one event (trigger, echo rise, echo fall, timeout check or
// result read) with its microsecond and millisecond time stamps, and each one
// gives exactly one result transaction with the flags, the last distance in
// signed q11.4 cm, the phase and the new-data flag after that event. A falling
// edge in the waiting-fall phase measures the pulse width modulo
// 2^US_TIMER_BITS us, multiplies it by cm_per_us_q16 and rounds to q4,
// saturating at 32767; a timeout check at or past timeout_ms in either waiting phase
// reports no_echo_distance_q4. The block takes one event per clock: all of the
// update runs as one pass of logic into a single output register, so a result
// appears in the cycle after its event is accepted, and s_tready is low only
// while that register holds a result that m_tready has not yet taken.
// Configuration writes take effect on the next event and never touch the
// stored distance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ultrasonic_echo_ranger_core #(
  parameter int US_TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,

  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,

  // event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // now_us[15:0], now_ms[47:16]
  input  logic [2:0]  s_tuser,   // action[2:0]

  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // trigger_started[0], read_ok[1], distance_q4[17:2],
                                 // phase_now[19:18], fresh[20], zero[23:21]
);

  // widths of the distance datapath
  localparam int PROD_W = US_TIMER_BITS + 16;
  localparam int SUM_W  = PROD_W + 1;
  localparam int Q4_W   = (SUM_W - 12 > 16) ? (SUM_W - 12) : 16;

  // configuration registers
  logic [15:0] timeout_ms;
  logic [15:0] cm_per_us_q16;
  logic [15:0] no_echo_distance_q4;

  // measurement state
  logic [1:0]               phase;
  logic [1:0]               phase_next;
  logic [US_TIMER_BITS-1:0] rise_stamp_us;
  logic [US_TIMER_BITS-1:0] rise_stamp_us_next;
  logic [31:0]              trigger_stamp_ms;
  logic [31:0]              trigger_stamp_ms_next;
  logic [31:0]              rise_stamp_ms;
  logic [31:0]              rise_stamp_ms_next;
  logic [15:0]              last_distance;
  logic [15:0]              last_distance_next;
  logic                     new_data_flag;
  logic                     new_data_flag_next;

  // event fields
  logic [2:0]               action;
  logic [15:0]              now_us;
  logic [31:0]              now_ms;
  logic [47:0]              now_us_wide;
  logic [US_TIMER_BITS-1:0] now_us_t;

  // datapath
  logic [US_TIMER_BITS-1:0] pulse_width;
  logic [PROD_W-1:0]        product;
  logic [SUM_W-1:0]         rounded;
  logic [Q4_W-1:0]          q4;
  logic [15:0]              measured;
  logic [31:0]              wait_from_ms;
  logic [31:0]              elapsed_ms;
  logic                     timed_out;

  logic trig;
  logic rd;
  logic s_accept;

  assign action = s_tuser;
  assign now_us = s_tdata[15:0];
  assign now_ms = s_tdata[47:16];

  // timer value at the counter width (zero extend or truncate)
  assign now_us_wide = {32'd0, now_us};
  assign now_us_t    = now_us_wide[US_TIMER_BITS-1:0];

  // output register frees up when its result is taken
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  // pulse width wraps with the microsecond counter
  assign pulse_width = now_us_t - rise_stamp_us;
  assign product     = PROD_W'(pulse_width) * PROD_W'(cm_per_us_q16);
  // q.16 to q.4 with round half up
  assign rounded     = SUM_W'(product) + SUM_W'(uer_pkg::ROUND_HALF);
  assign q4          = Q4_W'(rounded >> 12);
  assign measured    = (q4 > Q4_W'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX : q4[15:0];

  // timeout measured from trigger or from echo rise
  assign wait_from_ms = (phase == uer_pkg::PH_RISE) ? trigger_stamp_ms : rise_stamp_ms;
  assign elapsed_ms   = now_ms - wait_from_ms;
  assign timed_out    = elapsed_ms >= {16'd0, timeout_ms};

  always_comb begin
    phase_next            = phase;
    rise_stamp_us_next    = rise_stamp_us;
    trigger_stamp_ms_next = trigger_stamp_ms;
    rise_stamp_ms_next    = rise_stamp_ms;
    last_distance_next    = last_distance;
    new_data_flag_next    = new_data_flag;
    trig                  = 1'b0;
    rd                    = 1'b0;
    unique case (action)
      uer_pkg::ACT_TRIGGER: begin
        // only a fresh start from idle fires the sensor
        if (phase == uer_pkg::PH_IDLE) begin
          phase_next            = uer_pkg::PH_RISE;
          trigger_stamp_ms_next = now_ms;
          rise_stamp_ms_next    = 32'd0;
          new_data_flag_next    = 1'b0;
          trig                  = 1'b1;
        end
      end
      uer_pkg::ACT_RISE: begin
        if (phase == uer_pkg::PH_RISE) begin
          rise_stamp_us_next = now_us_t;
          rise_stamp_ms_next = now_ms;
          phase_next         = uer_pkg::PH_FALL;
        end
      end
      uer_pkg::ACT_FALL: begin
        if (phase == uer_pkg::PH_FALL) begin
          last_distance_next = measured;
          new_data_flag_next = 1'b1;
          phase_next         = uer_pkg::PH_IDLE;
        end
      end
      uer_pkg::ACT_TIMEOUT: begin
        // give up and report the no-echo distance
        if (phase != uer_pkg::PH_IDLE && timed_out) begin
          phase_next         = uer_pkg::PH_IDLE;
          last_distance_next = no_echo_distance_q4;
          new_data_flag_next = 1'b1;
        end
      end
      uer_pkg::ACT_READ: begin
        if (new_data_flag) begin
          new_data_flag_next = 1'b0;
          rd                 = 1'b1;
        end
      end
      default: begin
        // unused codes leave the state alone but still give a result
      end
    endcase
  end

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms          <= uer_pkg::TIMEOUT_MS_RST;
      cm_per_us_q16       <= uer_pkg::CM_PER_US_RST;
      no_echo_distance_q4 <= uer_pkg::NO_ECHO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uer_pkg::REG_TIMEOUT_MS: timeout_ms          <= cfg_wdata;
        uer_pkg::REG_CM_PER_US:  cm_per_us_q16       <= cfg_wdata;
        uer_pkg::REG_NO_ECHO:    no_echo_distance_q4 <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // state moves only on an accepted event
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= uer_pkg::PH_IDLE;
      rise_stamp_us    <= '0;
      trigger_stamp_ms <= 32'd0;
      rise_stamp_ms    <= 32'd0;
      last_distance    <= uer_pkg::NO_ECHO_RST;
      new_data_flag    <= 1'b0;
    end else if (s_accept) begin
      phase            <= phase_next;
      rise_stamp_us    <= rise_stamp_us_next;
      trigger_stamp_ms <= trigger_stamp_ms_next;
      rise_stamp_ms    <= rise_stamp_ms_next;
      last_distance    <= last_distance_next;
      new_data_flag    <= new_data_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tdata <= {3'd0, new_data_flag_next, phase_next, last_distance_next, rd, trig};
    end
  end

  // a stalled result blocks new events
  `ASSERT_CLK_RST(a_stall_blocks, clk, rst, (m_tvalid && !m_tready) |-> !s_tready)
  // a fired trigger leaves the block waiting for the rise with no fresh data
  `ASSERT_CLK_RST(a_trig_result, clk, rst,
    (m_tvalid && m_tdata[0]) |-> (m_tdata[19:18] == uer_pkg::PH_RISE && !m_tdata[20]))
  // a successful read consumes the flag
  `ASSERT_CLK_RST(a_read_clears, clk, rst, (m_tvalid && m_tdata[1]) |-> !m_tdata[20])
  // a trigger taken while idle starts a measurement and posts a result
  `ASSERT_CLK_RST(a_trig_starts, clk, rst,
    (s_accept && action == uer_pkg::ACT_TRIGGER && phase == uer_pkg::PH_IDLE)
      |=> (phase == uer_pkg::PH_RISE && m_tvalid && m_tdata[0]))

endmodule

[tb/tb_ultrasonic_echo_ranger_core.sv]
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger_core
// Self-checking bench for the echo ranging core. Events go in on the slave
// stream, and a scoreboard class keeps its own copy of the phase, the stamps,
// the stored distance and the new-data flag. It works out the result of every
// accepted event and compares each result transaction field by field. The run
// starts with a directed pass over the corner cases. It then sends mostly
// well-formed trigger/rise/fall/read sequences with random timing, and some
// broken sequences and noise. Five register settings are used, the extremes
// among them, under several pacing patterns, with one long result stall.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger_core;
  timeunit 1ns;
  timeprecision 1ps;

  // action codes the core must ignore
  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  // cycles without any transaction before the run is declared hung
  localparam int STALL_LIMIT = 5000;
  // length of the forced result stall
  localparam int LONG_HOLD = 300;
  // product at which the distance first clips: 32768 * 4096 - 2048
  localparam logic [31:0] CLIP_PRODUCT = 32'd134215680;

  typedef struct packed {
    logic        trig;
    logic        rd;
    logic [15:0] dist_q4;
    logic [1:0]  ph;
    logic        fresh;
  } ranger_report_t;

  // --------------------------------------------------------------------------
  // scoreboard: predicts one report per event and checks results in order
  // --------------------------------------------------------------------------
  class echo_ranger_scoreboard;
    logic [15:0] timeout_ms, cm_per_us, no_echo;
    logic [1:0]  phase;
    logic [15:0] rise_us, distance;
    logic [31:0] trig_ms, rise_ms;
    logic        fresh;
    ranger_report_t expected_reports[$];
    int errors, results, triggers, echoes, clipped, timeouts, reads_ok;

    function new();
      timeout_ms = uer_pkg::TIMEOUT_MS_RST;
      cm_per_us  = uer_pkg::CM_PER_US_RST;
      no_echo    = uer_pkg::NO_ECHO_RST;
      phase      = uer_pkg::PH_IDLE;
      rise_us    = '0;
      trig_ms    = '0;
      rise_ms    = '0;
      distance   = uer_pkg::NO_ECHO_RST;
      fresh      = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        uer_pkg::REG_TIMEOUT_MS: timeout_ms = val;
        uer_pkg::REG_CM_PER_US:  cm_per_us  = val;
        uer_pkg::REG_NO_ECHO:    no_echo    = val;
        default: ;
      endcase
    endfunction

    // notes one accepted event and queues its expected report
    function void predict_event(logic [2:0] act, logic [15:0] us, logic [31:0] ms);
      ranger_report_t r;
      logic [15:0] width;
      logic [32:0] scaled;
      logic [31:0] elapsed;
      r = '0;
      case (act)
        uer_pkg::ACT_TRIGGER: begin
          if (phase == uer_pkg::PH_IDLE) begin
            phase   = uer_pkg::PH_RISE;
            trig_ms = ms;
            rise_ms = '0;
            fresh   = 1'b0;
            r.trig  = 1'b1;
            triggers++;
          end
        end
        uer_pkg::ACT_RISE: begin
          if (phase == uer_pkg::PH_RISE) begin
            rise_us = us;
            rise_ms = ms;
            phase   = uer_pkg::PH_FALL;
          end
        end
        uer_pkg::ACT_FALL: begin
          if (phase == uer_pkg::PH_FALL) begin
            width  = us - rise_us;
            scaled = width * cm_per_us + uer_pkg::ROUND_HALF;
            scaled = scaled >> 12;
            if (scaled > uer_pkg::DIST_MAX) begin
              distance = uer_pkg::DIST_MAX;
              clipped++;
            end else begin
              distance = scaled[15:0];
            end
            fresh = 1'b1;
            phase = uer_pkg::PH_IDLE;
            echoes++;
          end
        end
        uer_pkg::ACT_TIMEOUT: begin
          if (phase != uer_pkg::PH_IDLE) begin
            elapsed = ms - ((phase == uer_pkg::PH_RISE) ? trig_ms : rise_ms);
            if (elapsed >= timeout_ms) begin
              phase    = uer_pkg::PH_IDLE;
              distance = no_echo;
              fresh    = 1'b1;
              timeouts++;
            end
          end
        end
        uer_pkg::ACT_READ: begin
          if (fresh) begin
            fresh = 1'b0;
            r.rd  = 1'b1;
            reads_ok++;
          end
        end
        default: ;
      endcase
      r.dist_q4 = distance;
      r.ph      = phase;
      r.fresh   = fresh;
      expected_reports.push_back(r);
    endfunction

    function void field_check(string field, logic [15:0] want_v, logic [15:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
      end
    endfunction

    function void check_report(logic [23:0] d);
      ranger_report_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t ns: result %h with no expectation, expected none, actual %h",
                 $time, d, d);
        return;
      end
      want = expected_reports.pop_front();
      results++;
      field_check("trigger_started", want.trig, d[0]);
      field_check("read_ok", want.rd, d[1]);
      field_check("distance_q4", want.dist_q4, d[17:2]);
      field_check("phase_now", want.ph, d[19:18]);
      field_check("fresh", want.fresh, d[20]);
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, dut
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        s_tvalid, s_tready;
  logic [47:0] s_tdata;   // now_us[15:0], now_ms[47:16]
  logic [2:0]  s_tuser;   // action[2:0]
  logic        m_tvalid, m_tready;
  logic [23:0] m_tdata;   // trigger_started[0], read_ok[1], distance_q4[17:2],
                          // phase_now[19:18], fresh[20], zero[23:21]

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ultrasonic_echo_ranger_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  echo_ranger_scoreboard range_board = new();

  // pacing knobs, percent of cycles idle or stalled
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int sink_hold_req  = 0;
  int events_done    = 0;
  logic [31:0] ms_base;

  // --------------------------------------------------------------------------
  // result side: checks every result transaction, stalls at random,
  // and runs one long hold-off when asked
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        range_board.check_report(m_tdata);
      if (sink_hold_req != 0) begin
        hold_left = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // watchdog: any transaction on either side counts as progress
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_ultrasonic_echo_ranger_core: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // event side
  // --------------------------------------------------------------------------

  // offers one event, with random idle cycles first, and logs it once taken
  task automatic send_event(input logic [2:0] act, input logic [15:0] us,
                            input logic [31:0] ms);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {ms, us};
    do @(posedge clk); while (!s_tready);
    range_board.predict_event(act, us, ms);
    events_done++;
  endtask

  // stop offering and wait out every outstanding result plus the pipe latency
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (range_board.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    range_board.set_reg(idx, val);
  endtask

  // registers only change with the core idle
  task automatic configure(input logic [15:0] tmo, input logic [15:0] cm,
                           input logic [15:0] no_echo);
    drain_results();
    write_reg(uer_pkg::REG_TIMEOUT_MS, tmo);
    write_reg(uer_pkg::REG_CM_PER_US, cm);
    write_reg(uer_pkg::REG_NO_ECHO, no_echo);
    cfg_we <= 1'b0;
  endtask

  // elapsed time for a timeout check, clustered on the limit
  function automatic logic [31:0] near_timeout();
    logic [31:0] lim;
    lim = range_board.timeout_ms;
    case ($urandom_range(4))
      0: return lim - 1;
      1: return lim;
      2: return lim + 1;
      3: return $urandom_range(0, lim);
      default: return $urandom;
    endcase
  endfunction

  // echo width in us; sometimes right at the point where the distance clips
  function automatic logic [15:0] echo_width();
    logic [31:0] knee;
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      3: begin
        if (range_board.cm_per_us == 0)
          return 16'($urandom);
        knee = CLIP_PRODUCT / range_board.cm_per_us + $urandom_range(0, 2) - 1;
        if (knee > 32'hFFFF)
          return 16'hFFFF;
        return knee[15:0];
      end
      default: return 16'($urandom_range(50, 30000));
    endcase
  endfunction

  // one ranging cycle; some shapes are broken on purpose
  task automatic echo_sequence();
    logic [31:0] t_trig, t_rise;
    logic [15:0] r_us, f_us;
    int shape;
    shape  = $urandom_range(19);
    ms_base = ms_base + $urandom_range(1, 500);
    t_trig = ms_base;
    send_event(uer_pkg::ACT_TRIGGER, 16'($urandom), t_trig);
    if (shape == 0)
      send_event(uer_pkg::ACT_TRIGGER, 16'($urandom), t_trig + 1);  // retrigger while busy
    if (shape == 1 || shape == 2)
      send_event(uer_pkg::ACT_TIMEOUT, 16'($urandom), t_trig + near_timeout());
    if (shape == 3) begin
      // echo never rises
      send_event(uer_pkg::ACT_TIMEOUT, 16'($urandom), t_trig + near_timeout());
    end else begin
      t_rise = t_trig + $urandom_range(0, 40);
      r_us   = 16'($urandom);
      send_event(uer_pkg::ACT_RISE, r_us, t_rise);
      if (shape == 4 || shape == 5)
        send_event(uer_pkg::ACT_TIMEOUT, 16'($urandom), t_rise + near_timeout());
      if (shape == 6)
        send_event(uer_pkg::ACT_RISE, 16'($urandom), t_rise + 1);   // second rise ignored
      f_us = r_us + echo_width();
      send_event(uer_pkg::ACT_FALL, f_us, t_rise + $urandom_range(0, 40));
    end
    send_event(uer_pkg::ACT_READ, 16'($urandom), ms_base + 50);
    if (shape >= 16)
      send_event(uer_pkg::ACT_READ, 16'($urandom), ms_base + 51);   // nothing left to read
    ms_base = ms_base + 100;
  endtask

  task automatic random_traffic(input int n);
    int stop_at;
    stop_at = events_done + n;
    while (events_done < stop_at) begin
      if ($urandom_range(4) == 0)
        send_event(3'($urandom_range(7)), 16'($urandom), $urandom);
      else
        echo_sequence();
    end
  endtask

  task automatic set_pacing(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // corner cases with the reset register values (timeout 60 ms)
  task automatic directed_checks();
    send_event(uer_pkg::ACT_READ, 16'h0000, 32'h0000_0000);     // read with nothing fresh
    send_event(uer_pkg::ACT_RISE, 16'hFFFF, 32'hFFFF_FFFF);     // rise while idle
    send_event(uer_pkg::ACT_FALL, 16'hFFFF, 32'hFFFF_FFFF);     // fall while idle
    send_event(uer_pkg::ACT_TIMEOUT, 16'h0000, 32'hFFFF_FFFF);  // timeout check while idle
    send_event(ACT_SPARE_5, 16'hFFFF, 32'h0000_0000);
    send_event(ACT_SPARE_6, 16'h0000, 32'hFFFF_FFFF);
    send_event(ACT_SPARE_7, 16'hFFFF, 32'hFFFF_FFFF);
    // timeout while waiting for the rise, across the ms wrap
    send_event(uer_pkg::ACT_TRIGGER, 16'h1234, 32'hFFFF_FFF0);
    send_event(uer_pkg::ACT_TRIGGER, 16'h1234, 32'hFFFF_FFF1);  // busy, ignored
    send_event(uer_pkg::ACT_FALL, 16'h0010, 32'hFFFF_FFF2);     // fall before rise
    send_event(uer_pkg::ACT_TIMEOUT, 16'h0000, 32'h0000_002B);  // 59 ms, not yet
    send_event(uer_pkg::ACT_TIMEOUT, 16'h0000, 32'h0000_002C);  // 60 ms, gives up
    send_event(uer_pkg::ACT_READ, 16'h0000, 32'h0000_0030);
    send_event(uer_pkg::ACT_READ, 16'h0000, 32'h0000_0031);
    // measured echo whose us timer wraps between rise and fall
    send_event(uer_pkg::ACT_TRIGGER, 16'h0000, 32'd100);
    send_event(uer_pkg::ACT_RISE, 16'd65530, 32'd110);
    send_event(uer_pkg::ACT_TIMEOUT, 16'h0000, 32'd169);        // 59 ms after the rise
    send_event(uer_pkg::ACT_RISE, 16'h0000, 32'd169);           // second rise ignored
    send_event(uer_pkg::ACT_FALL, 16'd4, 32'd170);
    send_event(uer_pkg::ACT_READ, 16'h0000, 32'd171);
    // zero width echo, then the widest one
    send_event(uer_pkg::ACT_TRIGGER, 16'h0000, 32'd200);
    send_event(uer_pkg::ACT_RISE, 16'h0000, 32'd201);
    send_event(uer_pkg::ACT_FALL, 16'h0000, 32'd202);
    send_event(uer_pkg::ACT_TRIGGER, 16'h0000, 32'd300);
    send_event(uer_pkg::ACT_RISE, 16'h0000, 32'd301);
    send_event(uer_pkg::ACT_FALL, 16'hFFFF, 32'd302);
  endtask

  // --------------------------------------------------------------------------
  // run sequence
  // --------------------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= uer_pkg::REG_TIMEOUT_MS;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= uer_pkg::ACT_TRIGGER;
    ms_base = $urandom;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset register values, back to back
    set_pacing(0, 0);
    directed_checks();
    random_traffic(150);

    // top of every register range, bursty sender
    configure(16'hFFFF, 16'hFFFF, 16'h7FFF);
    set_pacing(64, 0);
    random_traffic(190);

    // zero timeout and scale, most negative no-echo distance, slow receiver
    configure(16'h0000, 16'h0000, 16'h8000);
    set_pacing(0, 64);
    random_traffic(190);

    // smallest nonzero timeout and scale, zero no-echo distance, light gaps on both sides
    configure(16'h0001, 16'h0001, 16'h0000);
    set_pacing(7, 7);
    random_traffic(190);

    // realistic random settings; long result stall while events keep coming
    configure(16'($urandom_range(1, 200)), 16'($urandom_range(500, 3000)),
              16'($urandom));
    set_pacing(0, 0);
    sink_hold_req = LONG_HOLD;
    random_traffic(100);

    // sender pauses until the core has emptied, then resumes
    drain_results();
    set_pacing(7, 7);
    random_traffic(130);

    drain_results();
    repeat (4) @(posedge clk);

    $display("run covered %0d results: %0d triggers, %0d echoes (%0d clipped), %0d timeouts,",
             range_board.results, range_board.triggers, range_board.echoes,
             range_board.clipped, range_board.timeouts);
    $display("%0d reads consumed, 5 register settings, 4 pacing mixes and a %0d cycle stall",
             range_board.reads_ok, LONG_HOLD);
    if (range_board.errors == 0 && range_board.pending() == 0) begin
      $display("tb_ultrasonic_echo_ranger_core: PASS");
    end else begin
      $display("tb_ultrasonic_echo_ranger_core: FAIL");
    end
    $finish;
  end

endmodule
